### src/nrc_pkg.sv
// ----------------------------------------------------------------------------
// nrc_pkg
// shared types, constants and helpers for the nonce replay cache
// ----------------------------------------------------------------------------
package nrc_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_W           = 64;
  localparam int TIME_W          = 40;
  localparam int SLOT_W          = 8;
  localparam int LFSR_W          = 16;
  localparam int IN_W            = 144;
  localparam int OUT_W           = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    PLACE_REUSE  = 2'd0,
    PLACE_APPEND = 2'd1,
    PLACE_RANDOM = 2'd2,
    PLACE_NONE   = 2'd3
  } place_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_VICTIM,
    ST_FINISH
  } state_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

### src/nrc_table.sv
// ----------------------------------------------------------------------------
// nrc_table
// key and expiry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module nrc_table
  import nrc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [KEY_W-1:0]  wr_key,
  input  logic [TIME_W-1:0] wr_exp,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [KEY_W-1:0]  rd_key,
  output logic [TIME_W-1:0] rd_exp
);

  logic [KEY_W+TIME_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W+TIME_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_exp, wr_key};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_key = rd_data_r[KEY_W-1:0];
  assign rd_exp = rd_data_r[KEY_W+TIME_W-1:KEY_W];

endmodule

### src/nrc_victim.sv
// ----------------------------------------------------------------------------
// nrc_victim
// victim lfsr and a pipelined reciprocal-multiply remainder by the table depth
// ----------------------------------------------------------------------------
module nrc_victim
  import nrc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             done,
  output logic [IDX_W-1:0] slot
);

  localparam int PROD_W = 2 * LFSR_W;
  localparam logic [LFSR_W-1:0] RECIP   = LFSR_W'((1 << LFSR_W) / TABLE_DEPTH);
  localparam logic [LFSR_W-1:0] DEPTH_C = LFSR_W'(TABLE_DEPTH);

  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [LFSR_W-1:0] val_r, val_nxt;
  logic [LFSR_W-1:0] quo_r, quo_nxt;
  logic [LFSR_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [2:0]        stage_r, stage_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] quo_prod;
  logic [PROD_W-1:0] back_prod;
  logic [LFSR_W-1:0] rem_fix;

  // quotient estimate is exact or one short, so one correction step remains
  assign quo_prod  = {{LFSR_W{1'b0}}, val_r} * {{LFSR_W{1'b0}}, RECIP};
  assign back_prod = {{LFSR_W{1'b0}}, quo_r} * {{LFSR_W{1'b0}}, DEPTH_C};
  assign rem_fix   = rem_r - DEPTH_C;

  always_comb begin
    lfsr_nxt  = lfsr_r;
    val_nxt   = val_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    slot_nxt  = slot_r;
    stage_nxt = {stage_r[1:0], start};
    done_nxt  = stage_r[2];
    if (start) begin
      lfsr_nxt = lfsr_next(lfsr_r);
      val_nxt  = lfsr_next(lfsr_r);
    end
    if (stage_r[0]) begin
      quo_nxt = quo_prod[PROD_W-1:LFSR_W];
    end
    if (stage_r[1]) begin
      rem_nxt = val_r - back_prod[LFSR_W-1:0];
    end
    if (stage_r[2]) begin
      slot_nxt = (rem_r >= DEPTH_C) ? rem_fix[IDX_W-1:0] : rem_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r  <= LFSR_SEED;
      stage_r <= '0;
      done_r  <= 1'b0;
    end else begin
      lfsr_r  <= lfsr_nxt;
      stage_r <= stage_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    slot_r <= slot_nxt;
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

### src/nonce_replay_cache_unit.sv
// ----------------------------------------------------------------------------
// nonce_replay_cache_unit
// single-use nonce table with expiry, replay detection and slot recycling
// ----------------------------------------------------------------------------
// One transaction at a time: an item scans the filled entries through the
// table's registered read port, one entry per cycle. When the table is
// full, the nonce is not a replay and no entry has expired, the victim slot
// comes from the lfsr through a reciprocal-multiply remainder unit. The table
// needs no clearing pass: only entries below the fill count are ever read. A
// finished result waits in the output register while the next item is taken.
module nonce_replay_cache_unit
  import nrc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // nonce_key, now_time, expiry_time
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // replay, placement, slot_index
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  state_t state_r, state_nxt;

  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              hit_r, hit_nxt;
  logic              have_exp_r, have_exp_nxt;
  logic [IDX_W-1:0]  first_exp_r, first_exp_nxt;
  logic              res_replay_r, res_replay_nxt;
  place_t            res_place_r, res_place_nxt;
  logic [IDX_W-1:0]  res_slot_r, res_slot_nxt;
  logic              res_wr_r, res_wr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic              accept;
  logic              issue;
  logic              out_load;
  logic              live;
  logic              vic_start;
  logic              vic_done;
  logic [IDX_W-1:0]  vic_slot;
  logic [KEY_W-1:0]  rd_key;
  logic [TIME_W-1:0] rd_exp;
  logic [EXT_W-1:0]  slot_ext;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign issue     = (state_r == ST_SCAN) && (addr_r < fill_r);
  assign out_load  = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  assign live      = (rd_exp >= now_r);
  assign vic_start = (state_r == ST_DECIDE) && !hit_r && !have_exp_r &&
                     (fill_r == CNT_W'(TABLE_DEPTH));
  assign slot_ext  = EXT_W'(res_slot_r);

  nrc_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (out_load && res_wr_r),
    .wr_addr (res_slot_r),
    .wr_key  (key_r),
    .wr_exp  (exp_r),
    .rd_en   (issue),
    .rd_addr (addr_r[IDX_W-1:0]),
    .rd_key  (rd_key),
    .rd_exp  (rd_exp)
  );

  nrc_victim #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_victim (
    .clk   (clk),
    .rst_n (rst_n),
    .start (vic_start),
    .done  (vic_done),
    .slot  (vic_slot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !rd_v_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = vic_start ? ST_VICTIM : ST_FINISH;
      end
      ST_VICTIM: begin
        if (vic_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    key_nxt        = key_r;
    now_nxt        = now_r;
    exp_nxt        = exp_r;
    fill_nxt       = fill_r;
    addr_nxt       = addr_r;
    rd_v_nxt       = issue;
    rd_idx_nxt     = addr_r[IDX_W-1:0];
    hit_nxt        = hit_r;
    have_exp_nxt   = have_exp_r;
    first_exp_nxt  = first_exp_r;
    res_replay_nxt = res_replay_r;
    res_place_nxt  = res_place_r;
    res_slot_nxt   = res_slot_r;
    res_wr_nxt     = res_wr_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt      = in_tdata[KEY_W-1:0];
          now_nxt      = in_tdata[KEY_W+TIME_W-1:KEY_W];
          exp_nxt      = in_tdata[KEY_W+2*TIME_W-1:KEY_W+TIME_W];
          addr_nxt     = '0;
          hit_nxt      = 1'b0;
          have_exp_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
        end
        if (rd_v_r) begin
          if (live) begin
            if (rd_key == key_r) begin
              hit_nxt = 1'b1;
            end
          end else if (!have_exp_r) begin
            have_exp_nxt  = 1'b1;
            first_exp_nxt = rd_idx_r;
          end
        end
      end
      ST_DECIDE: begin
        res_replay_nxt = 1'b0;
        res_wr_nxt     = 1'b1;
        if (hit_r) begin
          res_replay_nxt = 1'b1;
          res_place_nxt  = PLACE_NONE;
          res_slot_nxt   = '0;
          res_wr_nxt     = 1'b0;
        end else if (have_exp_r) begin
          res_place_nxt = PLACE_REUSE;
          res_slot_nxt  = first_exp_r;
        end else if (!vic_start) begin
          res_place_nxt = PLACE_APPEND;
          res_slot_nxt  = fill_r[IDX_W-1:0];
        end else begin
          res_place_nxt = PLACE_RANDOM;
        end
      end
      ST_VICTIM: begin
        if (vic_done) begin
          res_slot_nxt = vic_slot;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_W-SLOT_W-3){1'b0}}, slot_ext[SLOT_W-1:0],
                           res_place_r, res_replay_r};
          if (res_place_r == PLACE_APPEND) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    now_r        <= now_nxt;
    exp_r        <= exp_nxt;
    addr_r       <= addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hit_r        <= hit_nxt;
    have_exp_r   <= have_exp_nxt;
    first_exp_r  <= first_exp_nxt;
    res_replay_r <= res_replay_nxt;
    res_place_r  <= res_place_nxt;
    res_slot_r   <= res_slot_nxt;
    res_wr_r     <= res_wr_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_replay_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2:1] == PLACE_NONE && out_tdata[10:3] == '0)
    else $error("replay result carries a placement");

  a_victim_done: assert property (@(posedge clk) disable iff (!rst_n)
    vic_done |-> state_r == ST_VICTIM)
    else $error("victim slot ready outside victim wait");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid && state_r == ST_IDLE)
    else $error("result load did not return to idle");

endmodule
